FILE: hdl/rca_pkg.sv
package rca_pkg;

    localparam int NODE_W        = 6;
    localparam int NODE_SLOTS    = 64;
    localparam int DIST_W        = 32;
    localparam int COST_W        = 63;
    localparam int MASK_W        = 64;
    localparam int NODE_COUNT_DEFAULT = 64;

    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_COST_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPOT_MASK = 1'b1;

    localparam logic [MASK_W-1:0] DEPOT_MASK_RESET = 64'd1;
    localparam logic [COST_W-1:0] COST_MAX         = {COST_W{1'b1}};

    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = 2;
    localparam int OUT_CNT_W      = 3;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_ROUTE = 1'b1
    } op_t;

    typedef enum logic
    {
        MODE_DISTANCE   = 1'b0,
        MODE_CUMULATIVE = 1'b1
    } cost_mode_t;

endpackage

FILE: hdl/rca_if.sv
interface rca_in_if;
    logic                        valid;
    logic                        ready;
    rca_pkg::op_t                op;
    logic [rca_pkg::NODE_W-1:0]  row_node;
    logic [rca_pkg::NODE_W-1:0]  col_node;
    logic [rca_pkg::DIST_W-1:0]  arc_distance;
    logic [rca_pkg::NODE_W-1:0]  route_node;
    logic                        route_start;
    logic                        route_end;

    modport source
    (
        output valid, op, row_node, col_node, arc_distance, route_node, route_start,
               route_end,
        input  ready
    );

    modport sink
    (
        input  valid, op, row_node, col_node, arc_distance, route_node, route_start,
               route_end,
        output ready
    );
endinterface

interface rca_out_if;
    logic                        valid;
    logic                        ready;
    logic [rca_pkg::COST_W-1:0]  route_cost;
    logic                        cost_saturated;

    modport source
    (
        output valid, route_cost, cost_saturated,
        input  ready
    );

    modport sink
    (
        input  valid, route_cost, cost_saturated,
        output ready
    );
endinterface

FILE: hdl/route_cost_accumulator_core.sv
// path: a route's cost passes the s1 and s2 registers, then is queued for out_ch
// throughput: one item per cycle; a single matrix read per route node, a saturating add in the
//   running and total stages; in_ch stalls only while four results are queued or in flight
// reset: route state and flags clear to zero, cost_mode to distance, depot_mask to node 0;
//   the distance matrix is not cleared and each entry must be loaded before a route reads it
module route_cost_accumulator_core
#(
    parameter int NODE_COUNT = rca_pkg::NODE_COUNT_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    rca_in_if.sink                              in_ch,
    rca_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [rca_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ROWS   = (NODE_COUNT < rca_pkg::NODE_SLOTS) ? NODE_COUNT
                                                               : rca_pkg::NODE_SLOTS;
    localparam int DEPTH  = ROWS * rca_pkg::NODE_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef struct packed
    {
        logic                start;
        logic                last;
        rca_pkg::cost_mode_t mode;
        logic                both_depot;
        logic                to_depot;
        logic                in_range;
    } s1_ctrl_t;

    typedef struct packed
    {
        logic [rca_pkg::COST_W-1:0] cost;
        logic                       sat;
    } result_t;

    // configuration
    rca_pkg::cost_mode_t              cost_mode_reg;
    logic [rca_pkg::MASK_W-1:0]       depot_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_mode_reg  <= rca_pkg::MODE_DISTANCE;
            depot_mask_reg <= rca_pkg::DEPOT_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rca_pkg::CFG_COST_MODE:
                begin
                    cost_mode_reg <= rca_pkg::cost_mode_t'(cfg_data[0]);
                end
                rca_pkg::CFG_DEPOT_MASK:
                begin
                    depot_mask_reg <= cfg_data[rca_pkg::MASK_W-1:0];
                end
                default:
                begin
                    cost_mode_reg <= cost_mode_reg;
                end
            endcase
        end
    end

    // input stage
    logic                           in_xfer;
    logic                           load_xfer;
    logic                           route_xfer;
    logic                           load_in_range;
    logic                           arc_in_range;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;
    logic [rca_pkg::NODE_W-1:0]     prev_node_reg;

    logic [rca_pkg::OUT_CNT_W-1:0]  fifo_count_reg;
    logic [rca_pkg::OUT_CNT_W-1:0]  pending;

    logic                           s1_valid_reg;
    s1_ctrl_t                       s1_ctrl_reg;
    logic [rca_pkg::DIST_W-1:0]     rd_data_reg;

    logic                           s2_valid_reg;
    logic                           s2_start_reg;
    logic                           s2_last_reg;
    logic                           s2_sat_reg;
    logic [rca_pkg::COST_W-1:0]     s2_addend_reg;

    assign pending = fifo_count_reg
                   + rca_pkg::OUT_CNT_W'(s1_valid_reg && s1_ctrl_reg.last)
                   + rca_pkg::OUT_CNT_W'(s2_valid_reg && s2_last_reg);

    assign in_ch.ready = (pending < rca_pkg::OUT_CNT_W'(rca_pkg::OUT_FIFO_DEPTH));
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign load_xfer   = in_xfer && (in_ch.op == rca_pkg::OP_LOAD);
    assign route_xfer  = in_xfer && (in_ch.op == rca_pkg::OP_ROUTE);

    assign load_in_range = (int'(in_ch.row_node) < NODE_COUNT)
                        && (int'(in_ch.col_node) < NODE_COUNT);
    assign arc_in_range  = (int'(prev_node_reg) < NODE_COUNT)
                        && (int'(in_ch.route_node) < NODE_COUNT);

    logic [2*rca_pkg::NODE_W-1:0] wr_full_addr;
    logic [2*rca_pkg::NODE_W-1:0] rd_full_addr;

    assign wr_full_addr = {in_ch.row_node, in_ch.col_node};
    assign rd_full_addr = {prev_node_reg, in_ch.route_node};
    assign wr_addr      = wr_full_addr[ADDR_W-1:0];
    assign rd_addr      = rd_full_addr[ADDR_W-1:0];

    // distance matrix
    logic [rca_pkg::DIST_W-1:0] dist_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (load_xfer && load_in_range)
        begin
            dist_mem[wr_addr] <= in_ch.arc_distance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (route_xfer && arc_in_range)
        begin
            rd_data_reg <= dist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_node_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_ctrl_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= route_xfer;
            if (route_xfer)
            begin
                prev_node_reg          <= in_ch.route_node;
                s1_ctrl_reg.start      <= in_ch.route_start;
                s1_ctrl_reg.last       <= in_ch.route_end;
                s1_ctrl_reg.mode       <= cost_mode_reg;
                s1_ctrl_reg.both_depot <= depot_mask_reg[prev_node_reg]
                                       && depot_mask_reg[in_ch.route_node];
                s1_ctrl_reg.to_depot   <= depot_mask_reg[in_ch.route_node];
                s1_ctrl_reg.in_range   <= arc_in_range;
            end
        end
    end

    // running distance stage
    logic [rca_pkg::COST_W-1:0] running_reg;
    logic [rca_pkg::COST_W-1:0] running_next;
    logic [rca_pkg::COST_W-1:0] arc_dist;
    logic [rca_pkg::COST_W:0]   run_sum;
    logic [rca_pkg::COST_W-1:0] addend_next;
    logic                       run_sat;

    assign arc_dist = s1_ctrl_reg.in_range ? rca_pkg::COST_W'(rd_data_reg) : '0;
    assign run_sum  = {1'b0, running_reg} + {1'b0, arc_dist};

    always_comb
    begin
        running_next = running_reg;
        addend_next  = '0;
        run_sat      = 1'b0;
        if (s1_ctrl_reg.start)
        begin
            running_next = '0;
        end
        else if (s1_ctrl_reg.mode == rca_pkg::MODE_CUMULATIVE)
        begin
            if (s1_ctrl_reg.to_depot)
            begin
                running_next = '0;
            end
            else if (run_sum[rca_pkg::COST_W])
            begin
                running_next = rca_pkg::COST_MAX;
                run_sat      = 1'b1;
            end
            else
            begin
                running_next = run_sum[rca_pkg::COST_W-1:0];
            end
            addend_next = running_next;
        end
        else
        begin
            addend_next = s1_ctrl_reg.both_depot ? '0 : arc_dist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            s2_start_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            s2_sat_reg    <= 1'b0;
            s2_addend_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                running_reg   <= running_next;
                s2_start_reg  <= s1_ctrl_reg.start;
                s2_last_reg   <= s1_ctrl_reg.last;
                s2_sat_reg    <= run_sat;
                s2_addend_reg <= addend_next;
            end
        end
    end

    // total cost stage
    logic [rca_pkg::COST_W-1:0] total_reg;
    logic [rca_pkg::COST_W-1:0] total_next;
    logic [rca_pkg::COST_W:0]   total_sum;
    logic                       sat_reg;
    logic                       sat_next;
    logic                       push;

    assign total_sum = {1'b0, total_reg} + {1'b0, s2_addend_reg};

    always_comb
    begin
        if (s2_start_reg)
        begin
            total_next = '0;
            sat_next   = 1'b0;
        end
        else if (total_sum[rca_pkg::COST_W])
        begin
            total_next = rca_pkg::COST_MAX;
            sat_next   = 1'b1;
        end
        else
        begin
            total_next = total_sum[rca_pkg::COST_W-1:0];
            sat_next   = sat_reg || s2_sat_reg;
        end
    end

    assign push = s2_valid_reg && s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            total_reg <= total_next;
            sat_reg   <= sat_next;
        end
    end

    // result queue
    result_t                        fifo_mem [rca_pkg::OUT_FIFO_DEPTH];
    logic [rca_pkg::OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [rca_pkg::OUT_PTR_W-1:0]  rd_ptr_reg;
    logic                           pop;
    result_t                        head;

    assign pop  = out_ch.valid && out_ch.ready;
    assign head = fifo_mem[rd_ptr_reg];

    assign out_ch.valid          = (fifo_count_reg != '0);
    assign out_ch.route_cost     = head.cost;
    assign out_ch.cost_saturated = head.sat;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{cost: total_next, sat: sat_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + rca_pkg::OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + rca_pkg::OUT_PTR_W'(1);
            end
            priority if (push && !pop)
            begin
                fifo_count_reg <= fifo_count_reg + rca_pkg::OUT_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fifo_count_reg <= fifo_count_reg - rca_pkg::OUT_CNT_W'(1);
            end
            else
            begin
                fifo_count_reg <= fifo_count_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= rca_pkg::OUT_CNT_W'(rca_pkg::OUT_FIFO_DEPTH))
        else $error("results in flight exceed queue depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_count_reg < rca_pkg::OUT_CNT_W'(rca_pkg::OUT_FIFO_DEPTH)))
        else $error("result pushed into full queue");

    a_single_node_route: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.op == rca_pkg::OP_ROUTE
            && in_ch.route_start && in_ch.route_end)
        |-> ##2 (push && total_next == '0 && !sat_next))
        else $error("one-node route did not give a zero cost");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = 8;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int LONG_ARCS    = 120;
    localparam int PHASE_ITEMS  = 115;

    typedef struct
    {
        rca_pkg::op_t               op;
        logic [rca_pkg::NODE_W-1:0] row_node;
        logic [rca_pkg::NODE_W-1:0] col_node;
        logic [rca_pkg::DIST_W-1:0] arc_distance;
        logic [rca_pkg::NODE_W-1:0] route_node;
        logic                       route_start;
        logic                       route_end;
    } rca_item_t;

    typedef struct packed
    {
        logic [rca_pkg::COST_W-1:0] route_cost;
        logic                       cost_saturated;
    } cost_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [rca_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rca_pkg::CFG_DATA_W-1:0]  cfg_data;

    rca_in_if  in_ch();
    rca_out_if out_ch();

    route_cost_accumulator_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // cost predictor state
    logic [rca_pkg::DIST_W-1:0] arc_matrix [0:rca_pkg::NODE_SLOTS*rca_pkg::NODE_SLOTS-1];
    bit                         arc_loaded [0:rca_pkg::NODE_SLOTS*rca_pkg::NODE_SLOTS-1];
    logic [rca_pkg::NODE_W-1:0] prev_stop;
    logic [rca_pkg::COST_W-1:0] run_dist;
    logic [rca_pkg::COST_W-1:0] route_total;
    logic                       clamp_seen;
    rca_pkg::cost_mode_t        mode_shadow;
    logic [rca_pkg::MASK_W-1:0] depot_shadow;

    cost_result_t expected_costs [$];
    int           mismatches;
    int           items_sent;
    bit           steady_sender;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("route_cost_accumulator_core test failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [rca_pkg::DIST_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return $urandom_range(0, 1000);
        return $urandom;
    endfunction

    function automatic logic [rca_pkg::NODE_W-1:0] pick_node();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r == 2)
            return '1;
        return rca_pkg::NODE_W'($urandom_range(0, rca_pkg::NODE_SLOTS - 1));
    endfunction

    function automatic logic [rca_pkg::COST_W-1:0] clamp_add(
        logic [rca_pkg::COST_W-1:0] a,
        logic [rca_pkg::COST_W-1:0] b);
        logic [rca_pkg::COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, rca_pkg::COST_MAX})
        begin
            clamp_seen = 1'b1;
            return rca_pkg::COST_MAX;
        end
        return s[rca_pkg::COST_W-1:0];
    endfunction

    function automatic void account_item(rca_item_t it);
        logic [rca_pkg::COST_W-1:0] d;
        cost_result_t               res;
        if (it.op == rca_pkg::OP_LOAD)
        begin
            arc_matrix[{it.row_node, it.col_node}] = it.arc_distance;
            arc_loaded[{it.row_node, it.col_node}] = 1'b1;
            return;
        end
        if (it.route_start)
        begin
            run_dist    = '0;
            route_total = '0;
            clamp_seen  = 1'b0;
        end
        else
        begin
            d = rca_pkg::COST_W'(arc_matrix[{prev_stop, it.route_node}]);
            if (mode_shadow == rca_pkg::MODE_DISTANCE)
            begin
                if (!(depot_shadow[prev_stop] && depot_shadow[it.route_node]))
                    route_total = clamp_add(route_total, d);
            end
            else
            begin
                if (depot_shadow[it.route_node])
                    run_dist = '0;
                else
                    run_dist = clamp_add(run_dist, d);
                route_total = clamp_add(route_total, run_dist);
            end
        end
        prev_stop = it.route_node;
        if (it.route_end)
        begin
            res.route_cost     = route_total;
            res.cost_saturated = clamp_seen;
            expected_costs     = {expected_costs, res};
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_item(input rca_item_t it);
        int gap;
        @(negedge clk);
        in_ch.valid        <= 1'b1;
        in_ch.op           <= it.op;
        in_ch.row_node     <= it.row_node;
        in_ch.col_node     <= it.col_node;
        in_ch.arc_distance <= it.arc_distance;
        in_ch.route_node   <= it.route_node;
        in_ch.route_start  <= it.route_start;
        in_ch.route_end    <= it.route_end;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        account_item(it);
        items_sent++;
        gap = steady_sender ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic load_entry(input logic [rca_pkg::NODE_W-1:0] row,
                              input logic [rca_pkg::NODE_W-1:0] col,
                              input logic [rca_pkg::DIST_W-1:0] d);
        rca_item_t it;
        it.op           = rca_pkg::OP_LOAD;
        it.row_node     = row;
        it.col_node     = col;
        it.arc_distance = d;
        it.route_node   = rca_pkg::NODE_W'($urandom);
        it.route_start  = 1'($urandom_range(0, 1));
        it.route_end    = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    // loads the arc first when the route would read an unwritten entry
    task automatic visit_node(input logic [rca_pkg::NODE_W-1:0] node, input bit first,
                              input bit last);
        rca_item_t it;
        if (!arc_loaded[{prev_stop, node}])
            load_entry(prev_stop, node, pick_distance());
        it.op           = rca_pkg::OP_ROUTE;
        it.row_node     = rca_pkg::NODE_W'($urandom);
        it.col_node     = rca_pkg::NODE_W'($urandom);
        it.arc_distance = $urandom;
        it.route_node   = node;
        it.route_start  = first;
        it.route_end    = last;
        send_item(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_costs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_register(input logic [rca_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [rca_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == rca_pkg::CFG_COST_MODE)
            mode_shadow = rca_pkg::cost_mode_t'(val[0]);
        else
            depot_shadow = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input rca_pkg::cost_mode_t mode,
                                  input logic [rca_pkg::MASK_W-1:0] mask);
        drain_results();
        set_register(rca_pkg::CFG_COST_MODE, rca_pkg::CFG_DATA_W'(mode));
        set_register(rca_pkg::CFG_DEPOT_MASK, mask);
    endtask

    task automatic test_matrix_extremes();
        load_entry(6'd0, 6'd0, 32'd0);
        load_entry(6'd0, 6'd63, 32'hFFFF_FFFF);
        load_entry(6'd63, 6'd0, 32'd1);
        load_entry(6'd63, 6'd63, 32'hA5A5_5A5A);
    endtask

    task automatic test_single_node_route();
        visit_node(6'd63, 1'b1, 1'b1);
        visit_node(6'd0, 1'b1, 1'b1);
    endtask

    task automatic test_distance_mode();
        visit_node(6'd0, 1'b1, 1'b0);
        visit_node(6'd0, 1'b0, 1'b0);
        visit_node(6'd63, 1'b0, 1'b0);
        visit_node(6'd63, 1'b0, 1'b0);
        visit_node(6'd0, 1'b0, 1'b1);
        apply_settings(rca_pkg::MODE_DISTANCE, 64'h8000_0000_0000_0001);
        visit_node(6'd0, 1'b1, 1'b0);
        visit_node(6'd63, 1'b0, 1'b0);
        visit_node(6'd0, 1'b0, 1'b1);
    endtask

    task automatic test_cumulative_mode();
        apply_settings(rca_pkg::MODE_CUMULATIVE, 64'h8000_0000_0000_0000);
        visit_node(6'd0, 1'b1, 1'b0);
        visit_node(6'd0, 1'b0, 1'b0);
        visit_node(6'd63, 1'b0, 1'b0);
        visit_node(6'd0, 1'b0, 1'b0);
        visit_node(6'd0, 1'b0, 1'b1);
    endtask

    task automatic test_continue_without_start();
        visit_node(6'd63, 1'b0, 1'b0);
        visit_node(6'd0, 1'b0, 1'b1);
        visit_node(6'd0, 1'b0, 1'b1);
    endtask

    // self arc at max distance, long back to back route with a cost midway
    task automatic test_long_max_route();
        int i;
        apply_settings(rca_pkg::MODE_CUMULATIVE, 64'd0);
        steady_sender = 1'b1;
        load_entry(6'd5, 6'd5, 32'hFFFF_FFFF);
        visit_node(6'd5, 1'b1, 1'b0);
        for (i = 1; i <= LONG_ARCS; i++)
            visit_node(6'd5, 1'b0, (i == LONG_ARCS / 2) || (i == LONG_ARCS));
        visit_node(6'd5, 1'b0, 1'b1);
        steady_sender = 1'b0;
        visit_node(6'd5, 1'b1, 1'b1);
    endtask

    task automatic test_random_routes();
        int  phase;
        int  budget_end;
        int  len;
        int  k;
        int  r;
        bit  broken;
        for (phase = 0; phase < 10; phase++)
        begin
            unique case (phase)
                0: apply_settings(rca_pkg::MODE_DISTANCE, 64'd1);
                1: apply_settings(rca_pkg::MODE_CUMULATIVE, 64'd1);
                2: apply_settings(rca_pkg::MODE_DISTANCE, 64'd0);
                3: apply_settings(rca_pkg::MODE_CUMULATIVE, 64'd0);
                4: apply_settings(rca_pkg::MODE_DISTANCE, '1);
                5: apply_settings(rca_pkg::MODE_CUMULATIVE, '1);
                6: apply_settings(rca_pkg::MODE_DISTANCE, {$urandom, $urandom});
                7: apply_settings(rca_pkg::MODE_CUMULATIVE, {$urandom, $urandom});
                8: apply_settings(rca_pkg::MODE_DISTANCE, 64'h8000_0000_0000_0001);
                default: apply_settings(rca_pkg::MODE_CUMULATIVE, {$urandom, $urandom});
            endcase
            steady_sender = (phase == 4) || (phase == 9);
            budget_end = items_sent + PHASE_ITEMS;
            while (items_sent < budget_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    load_entry(rca_pkg::NODE_W'($urandom), rca_pkg::NODE_W'($urandom),
                               pick_distance());
                else if (r < 13)
                    visit_node(pick_node(), 1'b0, 1'($urandom_range(0, 1)));
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
                    broken = ($urandom_range(0, 9) == 0);
                    for (k = 0; k < len; k++)
                        visit_node(pick_node(), k == 0, (k == len - 1) && !broken);
                    if ($urandom_range(0, 29) == 0)
                        drain_results();
                end
            end
        end
        steady_sender = 1'b0;
    endtask

    // result side backpressure
    initial
    begin
        int run;
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            repeat (run)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            gap = gap_len();
            repeat (gap)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
            end
        end
    end

    initial
    begin
        cost_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (expected_costs.size() == 0)
                    report_mismatch($sformatf("unexpected result cost %0d", out_ch.route_cost));
                else
                begin
                    want = expected_costs.pop_front();
                    if (out_ch.route_cost !== want.route_cost)
                        report_mismatch($sformatf("route_cost got %0d expected %0d",
                                                  out_ch.route_cost, want.route_cost));
                    if (out_ch.cost_saturated !== want.cost_saturated)
                        report_mismatch($sformatf("cost_saturated got %0b expected %0b",
                                                  out_ch.cost_saturated, want.cost_saturated));
                end
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = rca_pkg::CFG_COST_MODE;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.op           = rca_pkg::OP_LOAD;
        in_ch.row_node     = '0;
        in_ch.col_node     = '0;
        in_ch.arc_distance = '0;
        in_ch.route_node   = '0;
        in_ch.route_start  = 1'b0;
        in_ch.route_end    = 1'b0;
        prev_stop          = '0;
        run_dist           = '0;
        route_total        = '0;
        clamp_seen         = 1'b0;
        mode_shadow        = rca_pkg::MODE_DISTANCE;
        depot_shadow       = rca_pkg::DEPOT_MASK_RESET;
        mismatches         = 0;
        items_sent         = 0;
        steady_sender      = 1'b0;
        foreach (arc_loaded[i])
            arc_loaded[i] = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_matrix_extremes();
        test_single_node_route();
        test_distance_mode();
        test_cumulative_mode();
        test_continue_without_start();
        test_long_max_route();
        test_random_routes();

        drain_results();
        if (mismatches == 0)
            $display("route_cost_accumulator_core test passed");
        else
            $display("route_cost_accumulator_core test failed");
        $finish;
    end

endmodule
